>>> rtl/bitmap_page_allocator_macros.svh
// ----------------------------------------------------------------------------
// bitmap_page_allocator_macros.svh
// Assertion helpers for the bitmap page allocator. Empty under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on i_clk, off during reset
`define BPA_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bitmap_page_allocator: check failed");
// next-cycle implication
`define BPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bitmap_page_allocator: check failed");
`else
`define BPA_ASSERT(label, ante, cons)
`define BPA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int DEF_MAX_PAGES = 4096;
    localparam int DEF_WORD_BITS = 32;

    localparam int PAGE_W     = 20;
    localparam int RANGE_W    = 13;
    localparam int MODE_W     = 2;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    localparam logic [RANGE_W-1:0] COUNT_MAX = '1;

    // request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_USE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

    // response status
    localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE = 1'b1;

    typedef struct packed {
        logic fill;       // write one all-used word of the init pass
        logic load_req;   // capture request, reset scan pointers
        logic scan;       // advance bitmap scan one word
        logic take;       // claim the hit bit
        logic fail;       // no free page
        logic mark_calc;  // relative page, range check, word index
        logic mark_rd;    // read target word
        logic mark_wr;    // update target bit and count
        logic oor;        // page outside managed range
        logic out_load;   // move result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic              fill_last;
        logic [MODE_W-1:0] mode;
        logic              scan_hit;
        logic              scan_fail;
        logic              mark_oor;
    } t_dp_sts;

endpackage

>>> rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bpa_dp.sv
// ----------------------------------------------------------------------------
// bpa_dp
// Allocator datapath: bitmap RAM, scan pointers, mark path, count, result.
// ----------------------------------------------------------------------------
module bpa_dp #(
    parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES,
    parameter int WORD_BITS = bpa_pkg::DEF_WORD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bpa_pkg::t_dp_cmd                i_cmd,
    output bpa_pkg::t_dp_sts                o_sts,
    input  logic [bpa_pkg::MODE_W-1:0]      i_mode,
    input  logic [bpa_pkg::PAGE_W-1:0]      i_page,
    input  logic                            i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [bpa_pkg::PAGE_W-1:0]      o_grant,
    output logic [bpa_pkg::STAT_W-1:0]      o_status,
    output logic [bpa_pkg::RANGE_W-1:0]     o_free
);

    localparam int NUM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW        = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int RW        = bpa_pkg::RANGE_W;
    localparam int PW        = bpa_pkg::PAGE_W;
    localparam int BASE_W    = RW + 1;
    // reciprocal of WORD_BITS, exact for all RW-bit page indexes
    localparam int RECIP_SH  = RW + 7;
    localparam int RECIP_M   = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int CAP_I     = (MAX_PAGES > 8191) ? 8191 : MAX_PAGES;
    localparam logic [RW-1:0] CAP = RW'(CAP_I);

    // config
    logic [PW-1:0] r_base;
    logic [RW-1:0] r_range;
    logic [RW-1:0] w_eff;

    // request
    logic [bpa_pkg::MODE_W-1:0] r_mode;
    logic [PW-1:0]              r_page;

    // scan
    logic [AW-1:0]     r_fill_addr;
    logic [AW-1:0]     r_rd_idx;
    logic [BASE_W-1:0] r_rd_base;
    logic              r_chk_vld;
    logic [AW-1:0]     r_chk_idx;
    logic [BASE_W-1:0] r_chk_base;
    logic              w_issue_ok;
    logic [BASE_W-1:0] w_rem;
    logic [WORD_BITS-1:0] w_free_bits;
    logic [BW-1:0]     w_hit_bit;

    // mark
    logic [PW-1:0]        w_rel;
    logic [RW+RECIP_SH-1:0] w_prod;
    logic                 r_oor;
    logic [RW-1:0]        r_rel;
    logic [AW-1:0]        r_q;
    logic [BW-1:0]        r_bit;
    logic [RW-1:0]        w_bitv;
    logic [WORD_BITS-1:0] w_bit_mask;
    logic                 w_cur_used;
    logic                 w_want_used;
    logic                 w_change;

    // count and result
    logic [RW-1:0]               r_free;
    logic [bpa_pkg::STAT_W-1:0]  r_res_status;
    logic                        r_res_hit;
    logic [BASE_W-1:0]           r_res_idx;
    logic [PW-1:0]               r_out_grant;
    logic [bpa_pkg::STAT_W-1:0]  r_out_status;
    logic [RW-1:0]               r_out_free;

    // RAM
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic                 w_re;
    logic [AW-1:0]        w_raddr;
    logic [WORD_BITS-1:0] w_rdata;

    assign w_eff = (r_range > CAP) ? CAP : r_range;

    // scan
    assign w_issue_ok = r_rd_base < BASE_W'(w_eff);
    assign w_rem      = BASE_W'(w_eff) - r_chk_base;

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            w_free_bits[j] = !w_rdata[j] && (BASE_W'(j) < w_rem);
        end
    end

    always_comb begin
        w_hit_bit = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (w_free_bits[j]) begin
                w_hit_bit = BW'(j);
            end
        end
    end

    // mark
    assign w_rel       = r_page - r_base;
    assign w_prod      = (RW+RECIP_SH)'(w_rel[RW-1:0]) * (RW+RECIP_SH)'(RECIP_M);
    assign w_bitv      = r_rel - RW'(r_q * WORD_BITS);
    assign w_bit_mask  = WORD_BITS'(1) << r_bit;
    assign w_cur_used  = w_rdata[r_bit];
    assign w_want_used = (r_mode == bpa_pkg::MODE_USE);
    assign w_change    = (w_cur_used != w_want_used);

    // RAM ports
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_chk_idx;
        w_wdata = w_rdata | (WORD_BITS'(1) << w_hit_bit);
        if (i_cmd.fill) begin
            w_we    = 1'b1;
            w_waddr = r_fill_addr;
            w_wdata = '1;
        end else if (i_cmd.take) begin
            w_we    = 1'b1;
        end else if (i_cmd.mark_wr) begin
            w_we    = w_change;
            w_waddr = r_q;
            w_wdata = w_want_used ? (w_rdata | w_bit_mask) : (w_rdata & ~w_bit_mask);
        end
    end

    assign w_re    = (i_cmd.scan && w_issue_ok) || i_cmd.mark_rd;
    assign w_raddr = i_cmd.mark_rd ? r_q : r_rd_idx;

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_range     <= RW'(4096);
            r_fill_addr <= '0;
            r_chk_vld   <= 1'b0;
            r_free      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bpa_pkg::CFG_BASE:  r_base  <= i_cfg_data[PW-1:0];
                    bpa_pkg::CFG_RANGE: r_range <= i_cfg_data[RW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.fill) begin
                r_fill_addr <= r_fill_addr + AW'(1);
            end
            if (i_cmd.load_req) begin
                r_chk_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_chk_vld <= w_issue_ok;
            end
            if ((i_cmd.take || (i_cmd.mark_wr && w_change && w_want_used))
                && r_free != '0) begin
                r_free <= r_free - RW'(1);
            end else if (i_cmd.mark_wr && w_change && !w_want_used
                         && r_free != bpa_pkg::COUNT_MAX) begin
                r_free <= r_free + RW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_mode       <= i_mode;
            r_page       <= i_page;
            r_rd_idx     <= '0;
            r_rd_base    <= '0;
            r_res_status <= bpa_pkg::STAT_DONE;
            r_res_hit    <= 1'b0;
        end
        if (i_cmd.scan) begin
            r_chk_idx  <= r_rd_idx;
            r_chk_base <= r_rd_base;
            if (w_issue_ok) begin
                r_rd_idx  <= r_rd_idx + AW'(1);
                r_rd_base <= r_rd_base + BASE_W'(WORD_BITS);
            end
        end
        if (i_cmd.take) begin
            r_res_hit <= 1'b1;
            r_res_idx <= r_chk_base + BASE_W'(w_hit_bit);
        end
        if (i_cmd.fail) begin
            r_res_status <= bpa_pkg::STAT_NOFREE;
        end
        if (i_cmd.oor) begin
            r_res_status <= bpa_pkg::STAT_RANGE;
        end
        if (i_cmd.mark_calc) begin
            r_oor <= w_rel >= PW'(w_eff);
            r_rel <= w_rel[RW-1:0];
            r_q   <= AW'(w_prod[RW+RECIP_SH-1:RECIP_SH]);
        end
        if (i_cmd.mark_rd) begin
            r_bit <= BW'(w_bitv);
        end
        if (i_cmd.out_load) begin
            r_out_grant  <= r_res_hit ? (r_base + PW'(r_res_idx)) : '0;
            r_out_status <= r_res_status;
            r_out_free   <= r_free;
        end
    end

    assign o_sts.fill_last = (r_fill_addr == AW'(NUM_WORDS - 1));
    assign o_sts.mode      = r_mode;
    assign o_sts.scan_hit  = r_chk_vld && (|w_free_bits);
    assign o_sts.scan_fail = !r_chk_vld && !w_issue_ok;
    assign o_sts.mark_oor  = r_oor;

    assign o_grant  = r_out_grant;
    assign o_status = r_out_status;
    assign o_free   = r_out_free;

endmodule

>>> rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Allocator sequencer: init fill, dispatch, scan, mark, response handoff.
// ----------------------------------------------------------------------------
module bpa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    output logic             o_s_ready,
    output logic             o_m_valid,
    input  logic             i_m_ready,
    output bpa_pkg::t_dp_cmd o_cmd,
    input  bpa_pkg::t_dp_sts i_sts
);

    typedef enum logic [6:0] {
        ST_FILL = 7'b0000001,
        ST_IDLE = 7'b0000010,
        ST_DISP = 7'b0000100,
        ST_SCAN = 7'b0001000,
        ST_MRD  = 7'b0010000,
        ST_MWR  = 7'b0100000,
        ST_RESP = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = ST_DISP;
                end
            end
            ST_DISP: begin
                if (i_sts.mode == bpa_pkg::MODE_ALLOC) begin
                    n_state = ST_SCAN;
                end else if (i_sts.mode == bpa_pkg::MODE_USE
                             || i_sts.mode == bpa_pkg::MODE_FREE) begin
                    o_cmd.mark_calc = 1'b1;
                    n_state         = ST_MRD;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_hit) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_RESP;
                end else if (i_sts.scan_fail) begin
                    o_cmd.fail = 1'b1;
                    n_state    = ST_RESP;
                end
            end
            ST_MRD: begin
                if (i_sts.mark_oor) begin
                    o_cmd.oor = 1'b1;
                    n_state   = ST_RESP;
                end else begin
                    o_cmd.mark_rd = 1'b1;
                    n_state       = ST_MWR;
                end
            end
            ST_MWR: begin
                o_cmd.mark_wr = 1'b1;
                n_state       = ST_RESP;
            end
            ST_RESP: begin
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    assign n_out_valid = (r_out_valid && !i_m_ready) || o_cmd.out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_out_valid;

endmodule

>>> rtl/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit physical page allocator over a used/free bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis group: tuser carries the mode (allocate,
//   mark used, mark free), tdata the absolute page number for marks.
//   Every request yields exactly one response on m_axis: tdata holds the
//   granted page and the free count left, tuser the status. Config (base
//   page, managed page count) is written on the always-ready cfg channel;
//   the user must write it only while no request is in flight (unenforced).
// Throughput:
//   One request at a time. An allocate reads the bitmap words in order,
//   one RAM read per cycle, and stops at the first free page; one that finds
//   nothing reads all ceil(range / WORD_BITS) words. Marks read and write
//   back the target word (not when out of range); unused modes just respond.
// Reset:
//   The bitmap RAM is filled with all-used words, one word per cycle,
//   all ceil(MAX_PAGES / WORD_BITS) words (128 by default); no request is
//   taken meanwhile. Free count resets to zero.
// Stall:
//   The response sits in an output register; the next request is already
//   accepted and processed, and only waits at handoff if that register
//   is still held by the receiver.
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_macros.svh"

module bitmap_page_allocator #(
    parameter int MAX_PAGES = bpa_pkg::DEF_MAX_PAGES,
    parameter int WORD_BITS = bpa_pkg::DEF_WORD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [bpa_pkg::IN_DATA_W-1:0]   i_s_tdata,   // [19:0] page_number, pad
    input  logic [bpa_pkg::MODE_W-1:0]      i_s_tuser,   // [1:0] mode
    // response
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [bpa_pkg::OUT_DATA_W-1:0]  o_m_tdata,   // [19:0] granted_page,
                                                         // [32:20] free_left, pad
    output logic [bpa_pkg::STAT_W-1:0]      o_m_tuser,   // [1:0] status
    // config write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    bpa_pkg::t_dp_cmd w_cmd;
    bpa_pkg::t_dp_sts w_sts;

    logic [bpa_pkg::PAGE_W-1:0]  w_grant;
    logic [bpa_pkg::RANGE_W-1:0] w_free;

    assign o_cfg_ready = 1'b1;

    // sequencing
    bpa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .o_s_ready (o_s_tready),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .o_cmd     (w_cmd),
        .i_sts     (w_sts)
    );

    // bitmap, counters and result path
    bpa_dp #(
        .MAX_PAGES (MAX_PAGES),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_mode      (i_s_tuser),
        .i_page      (i_s_tdata[bpa_pkg::PAGE_W-1:0]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_grant     (w_grant),
        .o_status    (o_m_tuser),
        .o_free      (w_free)
    );

    assign o_m_tdata = {
        (bpa_pkg::OUT_DATA_W - bpa_pkg::PAGE_W - bpa_pkg::RANGE_W)'(0),
        w_free,
        w_grant
    };

    // one request in flight: no second accept right after one
    `BPA_ASSERT_NEXT(a_single_req, i_s_tvalid && o_s_tready, !o_s_tready)
    // a failed or rejected request never reports a page
    `BPA_ASSERT(a_no_grant_on_err, o_m_tvalid && o_m_tuser != bpa_pkg::STAT_DONE, w_grant == '0)
    // response handoff never overwrites an unread result
    `BPA_ASSERT(a_no_overwrite, w_cmd.out_load, !o_m_tvalid || i_m_tready)

endmodule
